[rtl/jump_list_range_classifier_assert.svh]
// Assertion macros for the jump list range classifier.
// Used by files that include it; needs a clk and rst in the including scope.
`ifndef JUMP_LIST_RANGE_CLASSIFIER_ASSERT_SVH
`define JUMP_LIST_RANGE_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define JLRC_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("jlrc: check failed");
`define JLRC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jlrc: check failed");
`else
`define JLRC_CHECK(label, expr)
`define JLRC_CHECK_NEXT(label, ante, cons)
`endif

`endif

[rtl/jlrc_pkg.sv]
// Shared types and constants for the jump list range classifier.
// No dependencies.
package jlrc_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] KIND_NEAR      = 2'd0;
  localparam logic [1:0] KIND_FAR       = 2'd1;
  localparam logic [1:0] KIND_SEG_FIRST = 2'd2;
  localparam logic [1:0] KIND_OFS_FIRST = 2'd3;

  localparam logic [1:0] CLASS_NONE     = 2'd0;
  localparam logic [1:0] CLASS_PLAIN    = 2'd1;
  localparam logic [1:0] CLASS_OFS_HALF = 2'd2;
  localparam logic [1:0] CLASS_SEG_HALF = 2'd3;

  localparam logic [2:0] SIZE_NONE  = 3'd0;
  localparam logic [2:0] SIZE_WORD  = 3'd2;
  localparam logic [2:0] SIZE_DWORD = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] segment;
    logic [15:0] offset;
    logic [15:0] length;
    logic [1:0]  kind;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic [1:0]         match_class;
    logic [2:0]         result_size;
    logic               start_flag;
    logic signed [15:0] other_half_distance;
  } res_t;

  // Stored range with end and midpoint precomputed at append time.
  typedef struct packed {
    logic [15:0] segment;
    logic [15:0] start;
    logic [16:0] end_ofs;
    logic [16:0] mid;
    logic [14:0] half;
    logic [1:0]  kind;
  } entry_t;

  // Lookup probe travelling down the cell row.
  typedef struct packed {
    logic               vld;
    logic [15:0]        segment;
    logic [15:0]        offset;
    logic               hit;
    logic [1:0]         match_class;
    logic [2:0]         result_size;
    logic               start_flag;
    logic signed [15:0] distance;
  } probe_t;

endpackage

[rtl/jump_list_range_classifier.sv]
// Top level of the jump list range classifier: control, range count, cell row.
// Depends on jlrc_pkg, jlrc_cell and jump_list_range_classifier_assert.svh.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one command per transaction:
//   clear the table, append a range, or look up an offset in a segment.
//   res channel (res_valid/res_ready/res) returns exactly one result per command.
//   A lookup walks the row of TABLE_ENTRIES cells, one cell per cycle; its
//   result is registered in the hold register and then in the result register.
//   A clear or append goes straight to the hold register.
//   One command at a time: a lookup occupies the block until its probe leaves
//   the cell row, so the length of the cell row sets its occupancy; no new
//   command is taken until the last result has moved to the result register.
//   The result register decouples the sides: a new command is taken while an
//   earlier result still waits. If res_ready stays low, the next result is
//   held internally and cmd_ready drops until the result register frees.
//   Reset empties the table (count to zero) and drops any pending result.
//   An append to a full table changes nothing and reports status 1.
`include "jump_list_range_classifier_assert.svh"

module jump_list_range_classifier #(
  parameter int TABLE_ENTRIES = jlrc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  jlrc_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output jlrc_pkg::res_t res
);
  import jlrc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  res_t             hold;
  logic             cmd_acc;
  logic             lookup_acc;
  logic             table_full;
  logic             append_drop;
  logic             res_load;
  logic             wr_en;
  entry_t           wr_entry;
  probe_t           head;
  probe_t           probe [TABLE_ENTRIES+1];
  probe_t           tail;

  assign cmd_ready   = (state == ST_IDLE) && !rst;
  assign cmd_acc     = cmd_valid && cmd_ready;
  assign lookup_acc  = cmd_acc && (cmd.action == ACT_LOOKUP);
  assign table_full  = (count == CNT_W'(TABLE_ENTRIES));
  assign append_drop = cmd_acc && (cmd.action == ACT_APPEND) && table_full;
  assign wr_en       = cmd_acc && (cmd.action == ACT_APPEND) && !table_full;
  assign res_load    = (state == ST_HOLD) && (!res_valid || res_ready);
  assign tail        = probe[TABLE_ENTRIES];

  always_comb begin
    wr_entry.segment = cmd.segment;
    wr_entry.start   = cmd.offset;
    wr_entry.end_ofs = {1'b0, cmd.offset} + {1'b0, cmd.length};
    wr_entry.half    = cmd.length[15:1];
    wr_entry.mid     = {1'b0, cmd.offset} + {2'b00, cmd.length[15:1]};
    wr_entry.kind    = cmd.kind;
  end

  always_comb begin
    head             = '0;
    head.vld         = lookup_acc;
    head.segment     = cmd.segment;
    head.offset      = cmd.offset;
    head.match_class = CLASS_NONE;
    head.result_size = SIZE_NONE;
  end

  assign probe[0] = head;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    jlrc_cell #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .INDEX         (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .count     (count),
      .wr_en     (wr_en),
      .wr_idx    (count[IDX_W-1:0]),
      .wr_entry  (wr_entry),
      .probe_in  (probe[i]),
      .probe_out (probe[i+1])
    );
  end

  // Control: state, range count, result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            case (cmd.action)
              ACT_CLEAR:  count <= '0;
              ACT_APPEND: if (!table_full) count <= count + 1'b1;
              default:    count <= count;
            endcase
            state <= (cmd.action == ACT_LOOKUP) ? ST_SCAN : ST_HOLD;
          end
        end
        ST_SCAN: if (tail.vld) state <= ST_HOLD;
        ST_HOLD: if (res_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_acc) begin
      hold <= res_t'({append_drop, 22'd0});
    end else if (state == ST_SCAN && tail.vld) begin
      hold.status              <= 1'b0;
      hold.match_class         <= tail.match_class;
      hold.result_size         <= tail.result_size;
      hold.start_flag          <= tail.start_flag;
      hold.other_half_distance <= tail.distance;
    end
    if (res_load) begin
      res <= hold;
    end
  end

  `JLRC_CHECK(a_count_bound, count <= CNT_W'(TABLE_ENTRIES))
  `JLRC_CHECK(a_scan_latency, tail.vld == $past(lookup_acc, TABLE_ENTRIES))
  `JLRC_CHECK_NEXT(a_full_keeps_count, append_drop, $stable(count))
  `JLRC_CHECK_NEXT(a_hold_loads, res_load, res_valid && state == ST_IDLE)

endmodule

[rtl/jlrc_cell.sv]
// One table slot: holds a single range and checks the passing probe against it.
// Depends on jlrc_pkg.
module jlrc_cell #(
  parameter int TABLE_ENTRIES = 256,
  parameter int INDEX         = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0]    count,
  input  logic                                  wr_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]      wr_idx,
  input  jlrc_pkg::entry_t                      wr_entry,
  input  jlrc_pkg::probe_t                      probe_in,
  output jlrc_pkg::probe_t                      probe_out
);
  import jlrc_pkg::*;

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  entry_t entry;
  probe_t probe_next;
  logic   in_range;
  logic   split;
  logic   first_half;
  logic   seg_half;

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == IDX_W'(INDEX)) begin
      entry <= wr_entry;
    end
  end

  always_comb begin
    split      = entry.kind[1];
    in_range   = (CNT_W'(INDEX) < count) && (entry.segment == probe_in.segment) &&
                 (probe_in.offset >= entry.start) &&
                 ({1'b0, probe_in.offset} < entry.end_ofs);
    first_half = {1'b0, probe_in.offset} < entry.mid;
    seg_half   = first_half != (entry.kind == KIND_OFS_FIRST);
    probe_next = probe_in;
    if (!probe_in.hit && in_range) begin
      probe_next.hit        = 1'b1;
      probe_next.start_flag = (probe_in.offset == entry.start) ||
                              (split && {1'b0, probe_in.offset} == entry.mid);
      if (!split) begin
        probe_next.match_class = CLASS_PLAIN;
        probe_next.result_size = (entry.kind == KIND_FAR) ? SIZE_DWORD : SIZE_WORD;
        probe_next.distance    = '0;
      end else begin
        probe_next.match_class = seg_half ? CLASS_SEG_HALF : CLASS_OFS_HALF;
        probe_next.result_size = SIZE_WORD;
        probe_next.distance    = first_half ? $signed({1'b0, entry.half})
                                            : $signed(16'd0 - {1'b0, entry.half});
      end
    end
  end

  // Only the valid bit is reset; the payload just follows it.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.vld <= 1'b0;
    end else begin
      probe_out.vld <= probe_in.vld;
    end
    probe_out.segment     <= probe_next.segment;
    probe_out.offset      <= probe_next.offset;
    probe_out.hit         <= probe_next.hit;
    probe_out.match_class <= probe_next.match_class;
    probe_out.result_size <= probe_next.result_size;
    probe_out.start_flag  <= probe_next.start_flag;
    probe_out.distance    <= probe_next.distance;
  end

endmodule
